>>> hw/rtl/vbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_pkg
// Shared types and constants of the box tracker.
// ----------------------------------------------------------------------------
package vbt_pkg;

    localparam int BOX_SLOTS = 8;
    localparam int SLOT_W    = $clog2(BOX_SLOTS);

    localparam logic [7:0] HDR_BYTE  = 8'hAA;
    localparam logic [7:0] END_BYTE  = 8'hFF;
    localparam logic [3:0] FRAME_LEN = 4'd10;

    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CTRL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_IMG_W  = 3'd0;
    localparam logic [2:0] REG_TGT_W  = 3'd1;
    localparam logic [2:0] REG_STALE  = 3'd2;
    localparam logic [2:0] REG_ALIGN  = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic           take_byte;
        logic           tick_start;
        logic           slot_en;
        logic [SLOT_W-1:0] slot;
        logic           tick_end;
        logic           scan_start;
        logic           ctrl_finish;
    } vbt_cmd_t;

    // Input word held during work.
    typedef struct packed {
        logic [3:0]  next_mode;
        logic [15:0] cruise_speed;
        logic [7:0]  rx_byte;
    } vbt_item_t;

    typedef struct packed {
        logic [15:0] box_centre_x;
        logic [15:0] widest_box_width;
        logic        tracking_done;
        logic [3:0]  mode_code;
        logic [15:0] speed_cmd;
        logic [15:0] yaw_cmd;
    } vbt_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/vision_box_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vision_box_tracker
// Camera box deframer and tracker with an APB register port.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         op, rx_byte, cruise_speed, next_mode
//  m_axis    out        yaw, speed, mode, done, width, centre
//  apb       in/out     five setup registers
// A byte word is handled in the idle state. A tick and a control request walk
// the slots, one table entry a cycle; a control request also waits for output.
// Reset clears both box tables and all frame state at once.
// A result still waiting in the output register holds a control request in
// its last cycle, and the input stays blocked until that result moves on.
// ----------------------------------------------------------------------------
module vision_box_tracker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] rx_byte, [23:8] cruise_speed, [27:24] next_mode
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] yaw, [31:16] speed, [35:32] mode, [51:36] width, [67:52] centre
    output logic [71:0]      m_axis_tdata,
    // [0] tracking_done
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vbt_pkg::*;

    vbt_cmd_t   cmd;
    vbt_item_t  item_reg;
    vbt_res_t   res;
    logic [15:0] img_reg, tgt_reg, stale_reg, align_reg;
    logic [3:0]  mode_reg;
    logic        ov_reg;
    logic [71:0] od_reg;
    logic        ou_reg;
    logic        acc;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign acc    = s_axis_tvalid && s_axis_tready;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg   <= 16'd320;
            tgt_reg   <= 16'd100;
            stale_reg <= 16'd50;
            align_reg <= '0;
            mode_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_IMG_W: img_reg   <= pwdata[15:0];
                REG_TGT_W: tgt_reg   <= pwdata[15:0];
                REG_STALE: stale_reg <= pwdata[15:0];
                REG_ALIGN: align_reg <= pwdata[15:0];
                REG_MODE:  mode_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_IMG_W: prdata = {16'd0, img_reg};
            REG_TGT_W: prdata = {16'd0, tgt_reg};
            REG_STALE: prdata = {16'd0, stale_reg};
            REG_ALIGN: prdata = {16'd0, align_reg};
            REG_MODE:  prdata = {28'd0, mode_reg};
            default:   prdata = '0;
        endcase
    end

    // Input word held for the datapath.
    vbt_item_t item_in;
    assign item_in = '{next_mode: s_axis_tdata[27:24],
                       cruise_speed: s_axis_tdata[23:8],
                       rx_byte: s_axis_tdata[7:0]};
    vbt_item_t item_cur;
    assign item_cur = acc ? item_in : item_reg;
    always_ff @(posedge clk)
    begin
        if (acc)
            item_reg <= item_in;
    end

    vbt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .out_free (!ov_reg || m_axis_tready),
        .cmd      (cmd)
    );

    vbt_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .item             (item_cur),
        .image_width      (img_reg),
        .target_box_width (tgt_reg),
        .stale_ticks      (stale_reg),
        .align_speed      (align_reg),
        .track_mode_code  (mode_reg),
        .res              (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.ctrl_finish)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ctrl_finish)
        begin
            od_reg <= {4'd0, res.box_centre_x, res.widest_box_width,
                       res.mode_code, res.speed_cmd, res.yaw_cmd};
            ou_reg <= res.tracking_done;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

`ifndef NO_ASSERTIONS
    // Finishing a control job never overwrites a waiting result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ctrl_finish |-> (!ov_reg || m_axis_tready))
        else $error("result overwritten");
    // Input is not taken while a job walks the slots.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.slot_en |-> !s_axis_tready)
        else $error("input taken while busy");
    // A completed control job always raises the output valid.
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ctrl_finish |=> m_axis_tvalid)
        else $error("result lost");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/vbt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_ctrl
// Sequencer: accepts a word, steps the datapath through slots, and hands the
// control result to the output register.
// ----------------------------------------------------------------------------
module vbt_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          in_op,
    output logic                     in_ready,
    input  wire logic                out_free,
    output vbt_pkg::vbt_cmd_t        cmd
);
    import vbt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TICK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              last;
    logic              kind_reg, kind_next;

    assign last     = (slot_reg == SLOT_W'(BOX_SLOTS - 1));
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.slot   = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = '0;
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_BYTE: cmd.take_byte = 1'b1;
                        OP_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next = ST_TICK;
                        end
                        OP_CTRL:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                        // The unused code is taken and dropped.
                        OP_UNUSED: ;
                    endcase
                end
            end
            ST_TICK:
            begin
                cmd.slot_en = 1'b1;
                slot_next   = slot_reg + 1'b1;
                if (last)
                    state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.slot_en = 1'b1;
                slot_next   = slot_reg + 1'b1;
                if (last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Tick finishes at once; a control result waits for the output.
                if (kind_reg)
                begin
                    if (out_free)
                    begin
                        cmd.ctrl_finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.tick_end = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Remembers whether the current job is a control request.
    always_comb
    begin
        kind_next = kind_reg;
        if (cmd.scan_start)
            kind_next = 1'b1;
        else if (cmd.tick_start)
            kind_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/vbt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_dp
// Datapath: frame assembly, box tables, stale timer, widest box scan and the
// steering arithmetic.
// ----------------------------------------------------------------------------
module vbt_dp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vbt_pkg::vbt_cmd_t  cmd,
    input  wire vbt_pkg::vbt_item_t item,
    input  wire logic [15:0]        image_width,
    input  wire logic [15:0]        target_box_width,
    input  wire logic [15:0]        stale_ticks,
    input  wire logic [15:0]        align_speed,
    input  wire logic [3:0]         track_mode_code,
    output vbt_pkg::vbt_res_t       res
);
    import vbt_pkg::*;

    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [7:0]  fslot_reg, fslot_next;
    logic [63:0] pay_reg, pay_next;
    logic [63:0] rcv_reg [BOX_SLOTS];
    logic [63:0] acc_reg [BOX_SLOTS];
    logic [15:0] timer_reg;
    logic        run_reg;
    logic [4:0]  settle_reg;
    logic [15:0] best_reg;
    logic [SLOT_W-1:0] sel_reg;
    logic        store;
    logic [63:0] pay_shift;
    logic        tick_mode_reg;

    // Frame assembly.
    always_comb
    begin
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        fslot_next = fslot_reg;
        pay_next   = pay_reg;
        store      = 1'b0;
        pay_shift  = 64'hFF << {cnt_reg[2:0] - 3'd2, 3'b000};
        if (cmd.take_byte)
        begin
            if (cnt_reg == 4'd0)
                hdr_next = item.rx_byte;
            else if (cnt_reg == 4'd1)
                fslot_next = item.rx_byte;
            else if (cnt_reg < FRAME_LEN)
                pay_next = (pay_reg & ~pay_shift)
                    | (64'(item.rx_byte) << {cnt_reg[2:0] - 3'd2, 3'b000});
            if (cnt_reg != 4'd15)
                cnt_next = cnt_reg + 4'd1;
            if (item.rx_byte == END_BYTE)
            begin
                store = (cnt_next >= FRAME_LEN) && (hdr_next == HDR_BYTE)
                    && (fslot_next < 8'(BOX_SLOTS));
                cnt_next = 4'd0;
            end
        end
    end

    // Tables and timer.
    logic        cur_diff;
    logic        clear_now;
    assign cur_diff  = (rcv_reg[cmd.slot] != acc_reg[cmd.slot]);
    assign clear_now = cmd.tick_end && (timer_reg > stale_ticks);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            hdr_reg   <= '0;
            fslot_reg <= '0;
            pay_reg   <= '0;
            timer_reg <= '0;
            run_reg   <= 1'b0;
            for (int i = 0; i < BOX_SLOTS; i++)
            begin
                rcv_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            fslot_reg <= fslot_next;
            pay_reg   <= pay_next;
            if (store)
                rcv_reg[fslot_next[SLOT_W-1:0]] <= pay_next;
            if (cmd.tick_start && run_reg && timer_reg != 16'hFFFF)
                timer_reg <= timer_reg + 16'd1;
            if (cmd.slot_en && !cmd.scan_start && tick_mode_reg && cur_diff)
            begin
                acc_reg[cmd.slot] <= rcv_reg[cmd.slot];
                timer_reg <= '0;
                run_reg   <= 1'b1;
            end
            if (clear_now)
            begin
                for (int i = 0; i < BOX_SLOTS; i++)
                begin
                    rcv_reg[i] <= '0;
                    acc_reg[i] <= '0;
                end
            end
        end
    end

    // Which job the slot walk belongs to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_mode_reg <= 1'b0;
        else if (cmd.tick_start)
            tick_mode_reg <= 1'b1;
        else if (cmd.scan_start)
            tick_mode_reg <= 1'b0;
    end

    // Widest box scan, one slot a cycle.
    logic [15:0] w_cur;
    assign w_cur = acc_reg[cmd.slot][31:16] - acc_reg[cmd.slot][15:0];
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            best_reg <= '0;
            sel_reg  <= '0;
        end
        else if (cmd.slot_en && !tick_mode_reg && w_cur > best_reg)
        begin
            best_reg <= w_cur;
            sel_reg  <= cmd.slot;
        end
    end

    // Steering arithmetic on the chosen box.
    logic [16:0] centre_w;
    logic [15:0] centre;
    logic signed [17:0] err, aerr;
    logic signed [17:0] tgt;
    logic [4:0]  settle_next;
    logic [15:0] x1;

    always_comb
    begin
        x1       = acc_reg[sel_reg][15:0];
        centre_w = {1'b0, x1} + {2'b00, best_reg[15:1]};
        centre   = centre_w[16] ? 16'hFFFF : centre_w[15:0];
        err      = $signed({2'b00, centre}) - $signed({3'b000, image_width[15:1]});
        aerr     = err[17] ? -err : err;
        tgt      = $signed({2'b00, target_box_width}) - 18'sd4;
        settle_next = settle_reg;
        res.widest_box_width = best_reg;
        res.box_centre_x     = centre;
        res.mode_code        = track_mode_code;
        res.tracking_done    = 1'b0;
        if ($signed({2'b00, best_reg}) < tgt)
        begin
            res.yaw_cmd   = (err > 18'sd32767) ? 16'h7FFF : err[15:0];
            res.speed_cmd = item.cruise_speed;
        end
        else if (aerr > 18'sd5)
        begin
            res.yaw_cmd   = err[17] ? 16'hFFA6 : 16'd90;
            res.speed_cmd = align_speed;
            if (aerr <= 18'sd8)
                settle_next = settle_reg + 5'd1;
        end
        else
        begin
            res.yaw_cmd       = '0;
            res.speed_cmd     = '0;
            res.mode_code     = item.next_mode;
            res.tracking_done = 1'b1;
            settle_next       = '0;
        end
        if (settle_next > 5'd10)
        begin
            res.yaw_cmd       = '0;
            res.speed_cmd     = '0;
            res.mode_code     = item.next_mode;
            res.tracking_done = 1'b1;
            settle_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= '0;
        else if (cmd.ctrl_finish)
            settle_reg <= settle_next;
    end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box tracker: directed frames, ticks and control
// requests, then random traffic in bursts, checked against typed-in results or
// a model of the deframer, the box tables and the steering law.
// ----------------------------------------------------------------------------
module tb;
    import vbt_pkg::*;

    typedef struct packed {
        logic [15:0] centre;
        logic [15:0] width;
        logic        done;
        logic [3:0]  mode;
        logic [15:0] speed;
        logic [15:0] yaw;
    } steer_t;

    // A word to send; has_exp marks a row whose result is typed in.
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic [15:0] cruise;
        logic [3:0]  next_mode;
        logic        has_exp;
        steer_t      exp_r;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] rx_byte, [23:8] cruise_speed, [27:24] next_mode
    logic [31:0] s_axis_tdata;
    // [1:0] op
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [15:0] yaw, [31:16] speed, [35:32] mode, [51:36] width, [67:52] centre
    logic [71:0] m_axis_tdata;
    // [0] tracking_done
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vision_box_tracker dut (.*);

    // Model state.
    logic [15:0] img_w, tgt_w, stale_lim, align_spd;
    logic [3:0]  track_mode;
    int unsigned fr_cnt;
    logic [7:0]  fr_hdr, fr_slot;
    logic [63:0] fr_payload;
    logic [63:0] rx_boxes [BOX_SLOTS];
    logic [63:0] acc_boxes [BOX_SLOTS];
    logic [15:0] stale_cnt;
    logic        timer_on;
    int unsigned settle;

    steer_t steer_q [$];
    int     errors;
    word_t  words [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic model_reset();
        img_w = 16'd320; tgt_w = 16'd100; stale_lim = 16'd50;
        align_spd = 16'd0; track_mode = 4'd0;
        fr_cnt = 0; fr_hdr = 8'd0; fr_slot = 8'd0; fr_payload = 64'd0;
        for (int i = 0; i < BOX_SLOTS; i++)
        begin
            rx_boxes[i] = 64'd0;
            acc_boxes[i] = 64'd0;
        end
        stale_cnt = 16'd0; timer_on = 1'b0; settle = 0;
    endtask

    // Deframer, table update and steering law for one accepted word.
    task automatic predict_word(input word_t w);
        int unsigned best, sel, x1, centre;
        int          err, aerr, yaw, spd;
        logic [3:0]  mode;
        logic        done;
        steer_t      r;
        if (w.op == OP_BYTE)
        begin
            if (fr_cnt == 0) fr_hdr = w.rx_byte;
            else if (fr_cnt == 1) fr_slot = w.rx_byte;
            else if (fr_cnt < 10) fr_payload[(fr_cnt-2)*8 +: 8] = w.rx_byte;
            if (fr_cnt < 15) fr_cnt++;
            if (w.rx_byte == END_BYTE)
            begin
                if (fr_cnt >= 10 && fr_hdr == HDR_BYTE && fr_slot < BOX_SLOTS)
                    rx_boxes[fr_slot] = fr_payload;
                fr_cnt = 0;
            end
        end
        else if (w.op == OP_TICK)
        begin
            if (timer_on && stale_cnt != 16'hFFFF) stale_cnt++;
            for (int i = 0; i < BOX_SLOTS; i++)
                if (rx_boxes[i] != acc_boxes[i])
                begin
                    acc_boxes[i] = rx_boxes[i];
                    stale_cnt = 16'd0;
                    timer_on = 1'b1;
                end
            if (stale_cnt > stale_lim)
                for (int i = 0; i < BOX_SLOTS; i++)
                begin
                    rx_boxes[i] = 64'd0;
                    acc_boxes[i] = 64'd0;
                end
        end
        else if (w.op == OP_CTRL)
        begin
            best = 0; sel = 0;
            for (int i = 0; i < BOX_SLOTS; i++)
            begin
                logic [15:0] wd;
                wd = acc_boxes[i][31:16] - acc_boxes[i][15:0];
                if (wd > best) begin best = wd; sel = i; end
            end
            x1 = acc_boxes[sel][15:0];
            centre = x1 + best / 2;
            if (centre > 65535) centre = 65535;
            err = int'(centre) - int'(img_w / 2);
            aerr = err < 0 ? -err : err;
            mode = track_mode; done = 1'b0;
            if (int'(best) < int'(tgt_w) - 4)
            begin
                yaw = err > 32767 ? 32767 : err;
                spd = $signed(w.cruise);
            end
            else if (aerr > 5)
            begin
                yaw = err > 0 ? 90 : -90;
                spd = $signed(align_spd);
                if (aerr <= 8) settle++;
            end
            else
            begin
                yaw = 0; spd = 0; mode = w.next_mode; done = 1'b1; settle = 0;
            end
            if (settle > 10)
            begin
                yaw = 0; spd = 0; mode = w.next_mode; done = 1'b1; settle = 0;
            end
            r.yaw = yaw[15:0]; r.speed = spd[15:0]; r.mode = mode; r.done = done;
            r.width = best[15:0]; r.centre = centre[15:0];
            if (w.has_exp)
                steer_q.push_back(w.exp_r);
            else
                steer_q.push_back(r);
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_IMG_W: img_w = val;
            REG_TGT_W: tgt_w = val;
            REG_STALE: stale_lim = val;
            REG_ALIGN: align_spd = val;
            REG_MODE:  track_mode = val[3:0];
            default: ;
        endcase
    endtask

    // Send every queued word with random bursts and gaps, then drain.
    task automatic send_words();
        int burst;
        burst = 0;
        while (words.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tuser = words[0].op;
            s_axis_tdata = {4'd0, words[0].next_mode, words[0].cruise, words[0].rx_byte};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            predict_word(words.pop_front());
            burst--;
            @(negedge clk);
            if (words.size() == 0 || burst == 0) s_axis_tvalid = 1'b0;
        end
        s_axis_tvalid = 1'b0;
        while (steer_q.size() > 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic word_t mk(input logic [1:0] op, input logic [7:0] b);
        word_t w;
        w.op = op; w.rx_byte = b;
        w.cruise = 16'($urandom); w.next_mode = 4'($urandom);
        w.has_exp = 1'b0; w.exp_r = '0;
        return w;
    endfunction

    task automatic push_frame(input logic [7:0] slot, input logic [15:0] x1,
                              input logic [15:0] x2);
        logic [63:0] p;
        p = {16'($urandom), 16'($urandom), x2, x1};
        words.push_back(mk(OP_BYTE, HDR_BYTE));
        words.push_back(mk(OP_BYTE, slot));
        for (int i = 0; i < 8; i++) words.push_back(mk(OP_BYTE, p[i*8 +: 8]));
        words.push_back(mk(OP_BYTE, END_BYTE));
    endtask

    // Receiver stall pattern and result check.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            case ($urandom_range(0, 3))
                0: m_axis_tready = 1'b0;
                default: m_axis_tready = 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            steer_t got;
            steer_t exp_r;
            got = {m_axis_tdata[67:36], m_axis_tuser, m_axis_tdata[35:0]};
            if (steer_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = steer_q.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // Directed rows: op, byte, cruise, next mode, typed-in flag, expected
    // result (centre, width, done, mode, speed, yaw).
    word_t dir_rows [10] = '{
        // Empty tables after reset: slot 0 default, centre error -160.
        '{OP_CTRL, 8'h00, 16'h7FFF, 4'hF, 1'b1,
          steer_t'{16'd0, 16'd0, 1'b0, 4'd0, 16'h7FFF, 16'hFF60}},
        '{OP_CTRL, 8'h00, 16'h8000, 4'h0, 1'b1,
          steer_t'{16'd0, 16'd0, 1'b0, 4'd0, 16'h8000, 16'hFF60}},
        '{OP_BYTE, 8'h00, 16'h0000, 4'h0, 1'b0, '0},   // bad header frame
        '{OP_BYTE, 8'hFF, 16'h0000, 4'h0, 1'b0, '0},
        '{OP_BYTE, 8'hAA, 16'h0000, 4'h0, 1'b0, '0},   // short frame
        '{OP_BYTE, 8'h01, 16'h0000, 4'h0, 1'b0, '0},
        '{OP_BYTE, 8'hFF, 16'h0000, 4'h0, 1'b0, '0},
        '{OP_TICK, 8'h00, 16'h0000, 4'h0, 1'b0, '0},
        // Tables still empty after the dropped frames.
        '{OP_CTRL, 8'h00, 16'h1234, 4'h5, 1'b1,
          steer_t'{16'd0, 16'd0, 1'b0, 4'd0, 16'h1234, 16'hFF60}},
        '{OP_UNUSED, 8'h55, 16'hFFFF, 4'hF, 1'b0, '0}  // unused op, ignored
    };

    initial
    begin
        int ctrl_seen;
        errors = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        model_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) words.push_back(dir_rows[i]);
        // Frames: good slot 7, bad slot 8, and two whose payload holds an end byte.
        push_frame(8'd7, 16'd100, 16'd300);
        push_frame(8'd8, 16'd0, 16'hFFFF);
        push_frame(8'd0, 16'hFF00, 16'hFFFF);
        words.push_back(mk(OP_TICK, 8'd0));
        words.push_back(mk(OP_CTRL, 8'd0));
        push_frame(8'd3, 16'd0, 16'hFFFF);
        words.push_back(mk(OP_TICK, 8'd0));
        words.push_back(mk(OP_CTRL, 8'd0));
        send_words();

        // Several register settings, extremes among them; random traffic each.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin reg_write(REG_IMG_W, 16'd1); reg_write(REG_TGT_W, 16'd0);
                         reg_write(REG_STALE, 16'd0); reg_write(REG_ALIGN, 16'h8000);
                         reg_write(REG_MODE, 16'hF); end
                1: begin reg_write(REG_IMG_W, 16'hFFFF); reg_write(REG_TGT_W, 16'hFFFF);
                         reg_write(REG_STALE, 16'hFFFF); reg_write(REG_ALIGN, 16'h7FFF);
                         reg_write(REG_MODE, 16'h0); end
                default: begin
                    reg_write(REG_IMG_W, 16'($urandom_range(100, 640)));
                    reg_write(REG_TGT_W, 16'($urandom_range(0, 300)));
                    reg_write(REG_STALE, 16'($urandom_range(0, 20)));
                    reg_write(REG_ALIGN, 16'($urandom));
                    reg_write(REG_MODE, 16'($urandom_range(0, 15)));
                end
            endcase
            ctrl_seen = 0;
            while (ctrl_seen < 330)
            begin
                int k;
                k = $urandom_range(0, 9);
                if (k < 4)
                begin
                    logic [15:0] x1;
                    x1 = (ph == 1) ? 16'($urandom) : 16'($urandom_range(0, 400));
                    push_frame(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                               8'($urandom_range(0, 7)), x1,
                               x1 + 16'($urandom_range(0, (ph == 1) ? 65535 : 200)));
                    ctrl_seen += 10;
                end
                else if (k < 5)
                begin
                    repeat ($urandom_range(1, 6))
                        words.push_back(mk(OP_BYTE, 8'($urandom)));
                    ctrl_seen += 2;
                end
                else if (k < 7)
                begin
                    words.push_back(mk(OP_TICK, 8'd0));
                    ctrl_seen++;
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) words.push_back(mk(OP_CTRL, 8'd0));
                    ctrl_seen += 2;
                end
            end
            send_words();
        end

        if (errors == 0 && steer_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/vbt_pkg.sv
hw/rtl/vbt_ctrl.sv
hw/rtl/vbt_dp.sv
hw/rtl/vision_box_tracker.sv
dv/tb.sv
